// File: src/rtwe_pkg.sv
// Shared widths, codes, payload types and saturating arithmetic for the route evaluator.
`default_nettype none

package rtwe_pkg;

	localparam int TIME_BITS   = 32;
	localparam int SUM_BITS    = 48;
	localparam int FIELD_W     = 32;
	localparam int OUT_W       = 48;
	localparam int COUNT_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_DEPOT_OPEN    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DEPOT_CLOSE   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DEPOT_SERVICE = CFG_IDX_W'(2);

	localparam logic MODE_VISIT = 1'b0;
	localparam logic MODE_CLOSE = 1'b1;

	typedef logic [TIME_BITS-1:0] tval_t;
	typedef logic [SUM_BITS-1:0]  sum_t;
	typedef logic [FIELD_W-1:0]   field_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [OUT_W-1:0]     out_t;

	localparam tval_t  TIME_MAX  = '1;
	localparam sum_t   SUM_MAX   = '1;
	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		tval_t open_t;
		tval_t close_t;
		tval_t service_t;
	} depot_t;

	typedef struct packed {
		logic   mode;
		logic   first;
		logic   empty;
		tval_t  inc;
		field_t leg_dist;
		tval_t  dur;
		field_t demand;
		tval_t  serv;
		field_t prize;
		tval_t  wopen;
		tval_t  wclose;
		field_t cap;
	} item_t;

	typedef struct packed {
		logic   mode;
		logic   empty;
		tval_t  wait_amt;
		tval_t  warp_amt;
		field_t leg_dist;
		tval_t  dur;
		field_t demand;
		tval_t  serv;
		field_t prize;
		field_t cap;
	} timed_t;

	function automatic tval_t clamp_time(field_t v);
		logic [63:0] w;
		w = 64'(v);
		if (w > 64'(TIME_MAX)) return TIME_MAX;
		return TIME_BITS'(w);
	endfunction

	function automatic tval_t add_time(tval_t a, tval_t b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic sum_t add_sum(sum_t a, logic [63:0] b);
		logic [63:0]     bc;
		logic [SUM_BITS:0] s;
		bc = (b > 64'(SUM_MAX)) ? 64'(SUM_MAX) : b;
		s = {1'b0, a} + (SUM_BITS + 1)'(bc);
		return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
	endfunction

	function automatic out_t to_out(sum_t s);
		logic [63:0] w;
		w = 64'(s);
		return w[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: src/rtwe_front.sv
// Request intake: clamps fields, tags first visit and empty close, folds service into travel.
`default_nettype none

module rtwe_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    mode,
	input  wire  [31:0]            leg_distance,
	input  wire  [31:0]            leg_duration,
	input  wire  [31:0]            client_demand,
	input  wire  [31:0]            client_service,
	input  wire  [31:0]            client_prize,
	input  wire  [31:0]            window_open,
	input  wire  [31:0]            window_close,
	input  wire  [31:0]            vehicle_capacity,
	input  rtwe_pkg::depot_t       depot,
	output logic                   push,
	output rtwe_pkg::item_t        push_item,
	input  wire                    q_ready
);
	import rtwe_pkg::*;

	logic  has_visit_q;
	tval_t prev_serv_q;
	tval_t serv_c;
	tval_t dur_c;
	tval_t serv_base;

	assign in_ready  = q_ready;
	assign push      = in_valid && q_ready;
	assign serv_c    = clamp_time(client_service);
	assign dur_c     = clamp_time(leg_duration);
	assign serv_base = has_visit_q ? prev_serv_q : depot.service_t;

	always_comb begin
		push_item.mode     = mode;
		push_item.first    = (mode == MODE_VISIT) && !has_visit_q;
		push_item.empty    = (mode == MODE_CLOSE) && !has_visit_q;
		push_item.inc      = add_time(serv_base, dur_c);
		push_item.leg_dist = leg_distance;
		push_item.dur      = dur_c;
		push_item.demand   = client_demand;
		push_item.serv     = serv_c;
		push_item.prize    = client_prize;
		push_item.wopen    = clamp_time(window_open);
		push_item.wclose   = clamp_time(window_close);
		push_item.cap      = vehicle_capacity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_visit_q <= 1'b0;
		end else if (push) begin
			has_visit_q <= (mode == MODE_VISIT);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (mode == MODE_VISIT)) begin
			prev_serv_q <= serv_c;
		end
	end

endmodule

`default_nettype wire

// File: src/rtwe_queue.sv
// Short request queue between intake and the evaluation pipeline.
`default_nettype none

module rtwe_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  rtwe_pkg::item_t        push_item,
	output logic                   q_ready,
	input  wire                    pop,
	output logic                   head_valid,
	output rtwe_pkg::item_t        head_item
);
	import rtwe_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_ready    = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: src/rtwe_timing.sv
// Running-time stage: arrival, wait, time warp and window clamp, one request per cycle while the accumulator takes it.
`default_nettype none

module rtwe_timing (
	input  wire                    clk,
	input  wire                    arst_n,
	input  rtwe_pkg::depot_t       depot,
	input  wire                    head_valid,
	input  rtwe_pkg::item_t        head_item,
	output logic                   pop,
	output logic                   valid_s1,
	output rtwe_pkg::timed_t       timed_s1,
	input  wire                    take
);
	import rtwe_pkg::*;

	tval_t  cur_time_q;
	tval_t  t_base;
	tval_t  t_arr;
	tval_t  t_raise;
	tval_t  t_new;
	tval_t  wait_c;
	tval_t  warp_c;
	timed_t timed_c;
	logic   adv;

	assign adv = !valid_s1 || take;
	assign pop = head_valid && adv;

	always_comb begin
		t_base  = head_item.first ? depot.open_t : cur_time_q;
		t_arr   = add_time(t_base, head_item.inc);
		wait_c  = '0;
		warp_c  = '0;
		t_raise = t_arr;
		t_new   = t_arr;
		if (head_item.mode == MODE_VISIT) begin
			if (t_arr < head_item.wopen) begin
				wait_c  = head_item.wopen - t_arr;
				t_raise = head_item.wopen;
			end
			t_new = t_raise;
			if (t_raise > head_item.wclose) begin
				warp_c = t_raise - head_item.wclose;
				t_new  = head_item.wclose;
			end
		end else if (t_arr > depot.close_t) begin
			warp_c = t_arr - depot.close_t;
		end

		timed_c.mode     = head_item.mode;
		timed_c.empty    = head_item.empty;
		timed_c.wait_amt = wait_c;
		timed_c.warp_amt = warp_c;
		timed_c.leg_dist = head_item.leg_dist;
		timed_c.dur      = head_item.dur;
		timed_c.demand   = head_item.demand;
		timed_c.serv     = head_item.serv;
		timed_c.prize    = head_item.prize;
		timed_c.cap      = head_item.cap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			timed_s1 <= timed_c;
			if (head_item.mode == MODE_VISIT) cur_time_q <= t_new;
		end
	end

endmodule

`default_nettype wire

// File: src/rtwe_accum.sv
// Route totals: saturating accumulators, excess load and the registered result.
`default_nettype none

module rtwe_accum (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    valid_s1,
	input  rtwe_pkg::timed_t       timed_s1,
	output logic                   take,
	output logic                   out_valid,
	input  wire                    out_ready,
	output rtwe_pkg::out_t         total_distance,
	output rtwe_pkg::out_t         total_duration,
	output rtwe_pkg::out_t         total_demand,
	output rtwe_pkg::out_t         total_service,
	output rtwe_pkg::out_t         total_prize,
	output rtwe_pkg::out_t         total_wait,
	output rtwe_pkg::out_t         total_warp,
	output rtwe_pkg::out_t         over_capacity,
	output rtwe_pkg::count_t       visit_count,
	output logic                   route_feasible
);
	import rtwe_pkg::*;

	sum_t   dist_sum_q;
	sum_t   dur_sum_q;
	sum_t   demand_sum_q;
	sum_t   serv_sum_q;
	sum_t   prize_sum_q;
	sum_t   wait_sum_q;
	sum_t   warp_sum_q;
	count_t visits_q;

	sum_t   dist_new;
	sum_t   dur_new;
	sum_t   warp_new;
	sum_t   cap_ext;
	sum_t   excess;
	logic   is_close;

	assign is_close = (timed_s1.mode == MODE_CLOSE);
	assign take     = valid_s1 && (!is_close || !out_valid || out_ready);
	assign dist_new = add_sum(dist_sum_q, 64'(timed_s1.leg_dist));
	assign dur_new  = add_sum(dur_sum_q, 64'(timed_s1.dur));
	assign warp_new = add_sum(warp_sum_q, 64'(timed_s1.warp_amt));
	assign cap_ext  = SUM_BITS'(timed_s1.cap);
	assign excess   = (demand_sum_q > cap_ext) ? demand_sum_q - cap_ext : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_sum_q   <= '0;
			dur_sum_q    <= '0;
			demand_sum_q <= '0;
			serv_sum_q   <= '0;
			prize_sum_q  <= '0;
			wait_sum_q   <= '0;
			warp_sum_q   <= '0;
			visits_q     <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (take && is_close) out_valid <= 1'b1;
			else if (out_ready)   out_valid <= 1'b0;
			if (take) begin
				if (is_close) begin
					dist_sum_q   <= '0;
					dur_sum_q    <= '0;
					demand_sum_q <= '0;
					serv_sum_q   <= '0;
					prize_sum_q  <= '0;
					wait_sum_q   <= '0;
					warp_sum_q   <= '0;
					visits_q     <= '0;
				end else begin
					dist_sum_q   <= dist_new;
					dur_sum_q    <= dur_new;
					demand_sum_q <= add_sum(demand_sum_q, 64'(timed_s1.demand));
					serv_sum_q   <= add_sum(serv_sum_q, 64'(timed_s1.serv));
					prize_sum_q  <= add_sum(prize_sum_q, 64'(timed_s1.prize));
					wait_sum_q   <= add_sum(wait_sum_q, 64'(timed_s1.wait_amt));
					warp_sum_q   <= warp_new;
					if (visits_q != COUNT_MAX) visits_q <= visits_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_close) begin
			if (timed_s1.empty) begin
				total_distance <= '0;
				total_duration <= '0;
				total_demand   <= '0;
				total_service  <= '0;
				total_prize    <= '0;
				total_wait     <= '0;
				total_warp     <= '0;
				over_capacity  <= '0;
				visit_count    <= '0;
				route_feasible <= 1'b0;
			end else begin
				total_distance <= to_out(dist_new);
				total_duration <= to_out(dur_new);
				total_demand   <= to_out(demand_sum_q);
				total_service  <= to_out(serv_sum_q);
				total_prize    <= to_out(prize_sum_q);
				total_wait     <= to_out(wait_sum_q);
				total_warp     <= to_out(warp_new);
				over_capacity  <= to_out(excess);
				visit_count    <= visits_q;
				route_feasible <= (excess == '0) && (warp_sum_q == '0)
					&& (timed_s1.warp_amt == '0);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/route_time_window_evaluator.sv
// Top level of the route time-window evaluator.
`default_nettype none

// Takes one request per cycle while the queue has room: a client visit (mode 0) or a route
// close (mode 1). Each close request produces one result with the route totals, passing
// through the queue, the running-time stage register and the result register; visits
// produce none. The running-time stage does one saturating add and one window clamp per
// cycle, which sets the sustained rate of one request per cycle unless a close waits on
// out_ready; a four-entry queue separates intake from evaluation, and a registered result
// lets new requests enter while a result waits for out_ready. Depot registers are sampled
// when a route is evaluated, so write them only while no request is in flight.
module route_time_window_evaluator (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wen,
	input  wire  [rtwe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [31:0]                    cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            mode,
	input  wire  [31:0]                    leg_distance,
	input  wire  [31:0]                    leg_duration,
	input  wire  [31:0]                    client_demand,
	input  wire  [31:0]                    client_service,
	input  wire  [31:0]                    client_prize,
	input  wire  [31:0]                    window_open,
	input  wire  [31:0]                    window_close,
	input  wire  [31:0]                    vehicle_capacity,
	output logic                           out_valid,
	input  wire                            out_ready,
	output rtwe_pkg::out_t                 total_distance,
	output rtwe_pkg::out_t                 total_duration,
	output rtwe_pkg::out_t                 total_demand,
	output rtwe_pkg::out_t                 total_service,
	output rtwe_pkg::out_t                 total_prize,
	output rtwe_pkg::out_t                 total_wait,
	output rtwe_pkg::out_t                 total_warp,
	output rtwe_pkg::out_t                 over_capacity,
	output rtwe_pkg::count_t               visit_count,
	output logic                           route_feasible
);
	import rtwe_pkg::*;

	logic [31:0] open_q;
	logic [31:0] close_q;
	logic [31:0] service_q;
	depot_t      depot;

	logic   push;
	item_t  push_item;
	logic   q_ready;
	logic   pop;
	logic   head_valid;
	item_t  head_item;
	logic   valid_s1;
	timed_t timed_s1;
	logic   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= '0;
			close_q   <= '1;
			service_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEPOT_OPEN:    open_q    <= cfg_data;
				REG_DEPOT_CLOSE:   close_q   <= cfg_data;
				REG_DEPOT_SERVICE: service_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign depot.open_t    = clamp_time(open_q);
	assign depot.close_t   = clamp_time(close_q);
	assign depot.service_t = clamp_time(service_q);

	rtwe_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.leg_distance     (leg_distance),
		.leg_duration     (leg_duration),
		.client_demand    (client_demand),
		.client_service   (client_service),
		.client_prize     (client_prize),
		.window_open      (window_open),
		.window_close     (window_close),
		.vehicle_capacity (vehicle_capacity),
		.depot            (depot),
		.push             (push),
		.push_item        (push_item),
		.q_ready          (q_ready)
	);

	rtwe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rtwe_timing u_timing (
		.clk        (clk),
		.arst_n     (arst_n),
		.depot      (depot),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.valid_s1   (valid_s1),
		.timed_s1   (timed_s1),
		.take       (take)
	);

	rtwe_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.timed_s1       (timed_s1),
		.take           (take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.total_distance (total_distance),
		.total_duration (total_duration),
		.total_demand   (total_demand),
		.total_service  (total_service),
		.total_prize    (total_prize),
		.total_wait     (total_wait),
		.total_warp     (total_warp),
		.over_capacity  (over_capacity),
		.visit_count    (visit_count),
		.route_feasible (route_feasible)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the route time-window evaluator: directed and random routes.
module tb;
	import rtwe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam int RUN_LIMIT   = 300000;
	localparam int HOLD_CYCLES = 150;
	localparam int HOLD_AT     = 30;
	localparam int SETTLE      = 12;

	typedef struct {
		logic        mode;
		logic [31:0] leg_distance;
		logic [31:0] leg_duration;
		logic [31:0] client_demand;
		logic [31:0] client_service;
		logic [31:0] client_prize;
		logic [31:0] window_open;
		logic [31:0] window_close;
		logic [31:0] vehicle_capacity;
	} request_t;

	typedef struct {
		out_t   distance;
		out_t   duration;
		out_t   demand;
		out_t   service;
		out_t   prize;
		out_t   idle;
		out_t   warp;
		out_t   excess;
		count_t visits;
		logic   feasible;
	} route_totals_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 mode = 1'b0;
	logic [31:0]          leg_distance = '0;
	logic [31:0]          leg_duration = '0;
	logic [31:0]          client_demand = '0;
	logic [31:0]          client_service = '0;
	logic [31:0]          client_prize = '0;
	logic [31:0]          window_open = '0;
	logic [31:0]          window_close = '0;
	logic [31:0]          vehicle_capacity = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 total_distance;
	out_t                 total_duration;
	out_t                 total_demand;
	out_t                 total_service;
	out_t                 total_prize;
	out_t                 total_wait;
	out_t                 total_warp;
	out_t                 over_capacity;
	count_t               visit_count;
	logic                 route_feasible;

	route_time_window_evaluator DUT (.*);

	request_t      pending_q[$];
	route_totals_t totals_q[$];
	request_t      held;
	int            queued_count = 0;
	int            taken_count = 0;
	int            results_seen = 0;
	int            fail_count = 0;
	int            cycle_count = 0;
	int            send_gap = 0;
	int            send_calm = 0;
	int            ready_gap = 0;
	int            ready_calm = 0;
	int            hold_left = 0;

	tval_t  depot_open_cfg = '0;
	tval_t  depot_close_cfg = '1;
	tval_t  depot_service_cfg = '0;
	tval_t  run_time = '0;
	tval_t  prior_service = '0;
	sum_t   dist_acc = '0;
	sum_t   dur_acc = '0;
	sum_t   demand_acc = '0;
	sum_t   service_acc = '0;
	sum_t   prize_acc = '0;
	sum_t   idle_acc = '0;
	sum_t   warp_acc = '0;
	count_t stops = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("route_time_window_evaluator test failed");
			$finish;
		end
	end

	function automatic tval_t sat_time(tval_t a, tval_t b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic sum_t sat_total(sum_t a, logic [31:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + (SUM_BITS + 1)'(b);
		return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
	endfunction

	function automatic tval_t arrival_time(tval_t leg);
		tval_t t;
		t = (stops != 0) ? sat_time(run_time, prior_service)
			: sat_time(depot_open_cfg, depot_service_cfg);
		return sat_time(t, leg);
	endfunction

	task automatic evaluate_request(input request_t r);
		tval_t         t;
		sum_t          excess;
		route_totals_t res;
		if (r.mode == MODE_VISIT) begin
			t = arrival_time(r.leg_duration);
			dist_acc = sat_total(dist_acc, r.leg_distance);
			dur_acc = sat_total(dur_acc, r.leg_duration);
			demand_acc = sat_total(demand_acc, r.client_demand);
			service_acc = sat_total(service_acc, r.client_service);
			prize_acc = sat_total(prize_acc, r.client_prize);
			if (t < r.window_open) begin
				idle_acc = sat_total(idle_acc, r.window_open - t);
				t = r.window_open;
			end
			if (t > r.window_close) begin
				warp_acc = sat_total(warp_acc, t - r.window_close);
				t = r.window_close;
			end
			run_time = t;
			prior_service = r.client_service;
			if (stops != COUNT_MAX)
				stops++;
		end else begin
			res = '{default: '0};
			if (stops != 0) begin
				t = arrival_time(r.leg_duration);
				dist_acc = sat_total(dist_acc, r.leg_distance);
				dur_acc = sat_total(dur_acc, r.leg_duration);
				if (t > depot_close_cfg)
					warp_acc = sat_total(warp_acc, t - depot_close_cfg);
				excess = (demand_acc > SUM_BITS'(r.vehicle_capacity))
					? demand_acc - SUM_BITS'(r.vehicle_capacity) : '0;
				res.distance = dist_acc;
				res.duration = dur_acc;
				res.demand = demand_acc;
				res.service = service_acc;
				res.prize = prize_acc;
				res.idle = idle_acc;
				res.warp = warp_acc;
				res.excess = excess;
				res.visits = stops;
				res.feasible = (excess == 0) && (warp_acc == 0);
			end
			totals_q = {totals_q, res};
			dist_acc = '0;
			dur_acc = '0;
			demand_acc = '0;
			service_acc = '0;
			prize_acc = '0;
			idle_acc = '0;
			warp_acc = '0;
			stops = '0;
		end
	endtask

	task automatic report_failure(input string msg);
		if (fail_count < 100)
			$display("ERROR @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_failure($sformatf("route %0d %s: got %0h, want %0h",
				results_seen, name, got, want));
	endtask

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = 20;
		return $urandom_range(0, 8);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				evaluate_request(held);
				taken_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					held = pending_q.pop_front();
					mode <= held.mode;
					leg_distance <= held.leg_distance;
					leg_duration <= held.leg_duration;
					client_demand <= held.client_demand;
					client_service <= held.client_service;
					client_prize <= held.client_prize;
					window_open <= held.window_open;
					window_close <= held.window_close;
					vehicle_capacity <= held.vehicle_capacity;
					in_valid <= 1'b1;
					send_gap = draw_gap(send_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		route_totals_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (totals_q.size() == 0) begin
					report_failure($sformatf("route %0d: result with nothing expected",
						results_seen));
				end else begin
					want = totals_q.pop_front();
					compare_field("total_distance", 64'(total_distance),
						64'(want.distance));
					compare_field("total_duration", 64'(total_duration),
						64'(want.duration));
					compare_field("total_demand", 64'(total_demand), 64'(want.demand));
					compare_field("total_service", 64'(total_service),
						64'(want.service));
					compare_field("total_prize", 64'(total_prize), 64'(want.prize));
					compare_field("total_wait", 64'(total_wait), 64'(want.idle));
					compare_field("total_warp", 64'(total_warp), 64'(want.warp));
					compare_field("over_capacity", 64'(over_capacity), 64'(want.excess));
					compare_field("visit_count", 64'(visit_count), 64'(want.visits));
					compare_field("route_feasible", 64'(route_feasible),
						64'(want.feasible));
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
				else
					ready_gap = draw_gap(ready_calm);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add_request(input request_t r);
		pending_q = {pending_q, r};
		queued_count++;
	endtask

	task automatic add_visit(input logic [31:0] leg_len, dur, demand, serv, prize, wo, wc);
		request_t r;
		r = '{MODE_VISIT, leg_len, dur, demand, serv, prize, wo, wc, $urandom};
		add_request(r);
	endtask

	task automatic add_close(input logic [31:0] leg_len, dur, cap);
		request_t r;
		r = '{MODE_CLOSE, leg_len, dur, $urandom, $urandom, $urandom, $urandom, $urandom,
			cap};
		add_request(r);
	endtask

	function automatic logic [31:0] pick_value(int unsigned span);
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			default: return 32'($urandom_range(0, span));
		endcase
	endfunction

	task automatic queue_routes(input int budget);
		request_t    r;
		int          count;
		logic [31:0] clock_guess;
		logic [31:0] load_guess;
		while (budget > 0) begin
			if ($urandom_range(0, 6) == 0) begin
				r = '{1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
				add_request(r);
				budget--;
			end else begin
				count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
				clock_guess = depot_open_cfg + depot_service_cfg;
				load_guess = '0;
				repeat (count) begin
					r.mode = MODE_VISIT;
					r.leg_distance = pick_value(1000);
					r.leg_duration = pick_value(200);
					r.client_demand = pick_value(50);
					r.client_service = pick_value(60);
					r.client_prize = pick_value(500);
					r.vehicle_capacity = $urandom;
					clock_guess += r.leg_duration;
					r.window_open = clock_guess + 32'($urandom_range(0, 100)) - 32'd50;
					r.window_close = ($urandom_range(0, 7) == 0) ? pick_value(3000)
						: r.window_open + 32'($urandom_range(0, 150));
					clock_guess += r.client_service;
					load_guess += r.client_demand;
					add_request(r);
				end
				add_close(pick_value(1000), pick_value(200),
					($urandom_range(0, 3) == 0) ? pick_value(400)
					: load_guess + 32'($urandom_range(0, 40)) - 32'd20);
				budget -= count + 1;
			end
		end
		add_close($urandom, $urandom, $urandom);
	endtask

	task automatic settle();
		while (taken_count != queued_count || totals_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_DEPOT_OPEN:    depot_open_cfg = value;
			REG_DEPOT_CLOSE:   depot_close_cfg = value;
			REG_DEPOT_SERVICE: depot_service_cfg = value;
			default: ;
		endcase
	endtask

	initial begin
		logic [31:0] base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_close('1, '1, '1);
		add_visit('0, '0, '0, '0, '0, '0, '0);
		add_close('0, '0, '0);
		add_visit('1, '1, '1, '1, '1, '1, '1);
		add_visit('1, '1, '1, '1, '1, '1, '1);
		add_close('1, '1, '1);
		add_visit(32'd12, 32'd10, 32'd3, 32'd20, 32'd7, 32'd100, 32'd200);
		add_visit(32'd30, 32'd500, 32'd4, 32'd5, 32'd9, 32'd0, 32'd50);
		add_visit(32'd8, 32'd40, 32'd6, 32'd15, 32'd1, 32'd900, 32'd100);
		add_close(32'd7, 32'd25, 32'd5);
		add_visit(32'd3, 32'd10, 32'd20, 32'd1, 32'd2, 32'd0, '1);
		add_close(32'd3, 32'd10, 32'd20);
		settle();

		write_reg(REG_DEPOT_OPEN, 32'd1000);
		write_reg(REG_DEPOT_CLOSE, 32'd1200);
		write_reg(REG_DEPOT_SERVICE, 32'd50);
		add_close(32'd9, 32'd9, 32'd9);
		add_visit(32'd40, 32'd100, 32'd10, 32'd300, 32'd5, 32'd0, '1);
		add_close(32'd40, 32'd100, 32'd100);
		queue_routes(120);
		settle();

		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_DEPOT_OPEN, '1);
		write_reg(REG_DEPOT_CLOSE, '0);
		write_reg(REG_DEPOT_SERVICE, '1);
		add_visit(32'd1, 32'd5, 32'd1, 32'd1, 32'd1, 32'd0, '1);
		add_close(32'd1, 32'd5, 32'd0);
		queue_routes(60);
		settle();

		write_reg(REG_DEPOT_OPEN, '0);
		write_reg(REG_DEPOT_CLOSE, '1);
		write_reg(REG_DEPOT_SERVICE, '0);
		queue_routes(130);
		settle();

		base = 32'($urandom_range(0, 5000));
		write_reg(REG_DEPOT_OPEN, base);
		write_reg(REG_DEPOT_CLOSE, base + 32'($urandom_range(0, 3000)));
		write_reg(REG_DEPOT_SERVICE, 32'($urandom_range(0, 100)));
		queue_routes(130);
		settle();

		write_reg(REG_DEPOT_OPEN, $urandom);
		write_reg(REG_DEPOT_CLOSE, $urandom);
		write_reg(REG_DEPOT_SERVICE, $urandom);
		write_reg(REG_UNUSED, $urandom);
		queue_routes(60);
		settle();

		if (fail_count == 0)
			$display("route_time_window_evaluator test passed");
		else
			$display("route_time_window_evaluator test failed");
		$finish;
	end

endmodule
